// File: src/gcd_insert_between_adjacent_defines.svh
`ifndef GCD_INSERT_BETWEEN_ADJACENT_DEFINES_SVH
`define GCD_INSERT_BETWEEN_ADJACENT_DEFINES_SVH

// same-cycle implication, off while reset is held
`define GCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcd: assertion failed");

// next-cycle implication, off while reset is held
`define GCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcd: assertion failed");

`endif

// File: src/gcd_pkg.sv
package gcd_pkg;

    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: src/gcd_front.sv
module gcd_front #(
    parameter int IW = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    input  logic [31:0]             i_s_tdata,
    input  logic                    i_s_tlast,
    output logic                    o_s_tready,
    input  gcd_pkg::t_q_stat        i_q_stat,
    output logic                    o_push,
    output logic [2*IW+1:0]         o_entry
);
    import gcd_pkg::*;

    logic [IW-1:0] r_prev;
    logic          r_have;
    logic [IW-1:0] w_cur;

    assign w_cur      = i_s_tdata[IW-1:0];
    assign o_s_tready = !i_q_stat.full;
    assign o_push     = i_s_tvalid && o_s_tready;
    assign o_entry    = {r_have, i_s_tlast, r_prev, w_cur};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_have <= 1'b0;
        end else if (o_push) begin
            // end of sequence: start anew
            if (i_s_tlast) begin
                r_prev <= '0;
                r_have <= 1'b0;
            end else begin
                r_prev <= w_cur;
                r_have <= 1'b1;
            end
        end
    end

endmodule

// File: src/gcd_queue.sv
`include "gcd_insert_between_adjacent_defines.svh"

module gcd_queue #(
    parameter int WIDTH = 66
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [WIDTH-1:0]        i_data,
    input  logic                    i_pop,
    output logic [WIDTH-1:0]        o_data,
    output gcd_pkg::t_q_stat        o_stat
);
    import gcd_pkg::*;

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `GCD_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_stat.full)
    `GCD_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_stat.empty)

endmodule

// File: src/gcd_back.sv
`include "gcd_insert_between_adjacent_defines.svh"

module gcd_back #(
    parameter int IW = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  gcd_pkg::t_q_stat        i_q_stat,
    input  logic [2*IW+1:0]         i_entry,
    output logic                    o_pop,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [31:0]             o_m_tdata,
    output logic                    o_m_tuser,
    output logic                    o_m_tlast
);
    import gcd_pkg::*;

    localparam int KW = $clog2(IW + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_GCD,
        S_VAL
    } t_state;

    t_state          r_state;
    logic [IW-1:0]   r_a;
    logic [IW-1:0]   r_b;
    logic [KW-1:0]   r_k;
    logic [IW-1:0]   r_val;
    logic            r_last;
    logic            r_ovalid;
    logic [DATA_W-1:0] r_odata;
    logic            r_ouser;
    logic            r_olast;

    logic            w_free;
    logic            w_done;
    logic [IW-1:0]   w_gcd;
    logic [IW-1:0]   w_amb;
    logic [IW-1:0]   w_bma;
    logic            w_load;

    assign w_free = !r_ovalid || i_m_tready;
    assign w_done = (r_a == '0) || (r_b == '0);
    assign w_gcd  = ((r_a == '0) ? r_b : r_a) << r_k;
    assign w_amb  = r_a - r_b;
    assign w_bma  = r_b - r_a;
    assign w_load = w_free && (((r_state == S_GCD) && w_done) || (r_state == S_VAL));
    assign o_pop  = (r_state == S_IDLE) && !i_q_stat.empty;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
    assign o_m_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= w_load || (r_ovalid && !i_m_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_b     <= i_entry[IW-1:0];
                        r_a     <= i_entry[2*IW-1:IW];
                        r_val   <= i_entry[IW-1:0];
                        r_last  <= i_entry[2*IW];
                        r_k     <= '0;
                        r_state <= i_entry[2*IW+1] ? S_GCD : S_VAL;
                    end
                end
                S_GCD: begin
                    if (w_done) begin
                        if (w_free) begin
                            r_odata <= DATA_W'(w_gcd);
                            r_ouser <= 1'b1;
                            r_olast <= 1'b0;
                            r_state <= S_VAL;
                        end
                    end else if (!r_a[0] && !r_b[0]) begin
                        r_a <= r_a >> 1;
                        r_b <= r_b >> 1;
                        r_k <= r_k + 1'b1;
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (r_a >= r_b) begin
                        r_a <= w_amb >> 1;
                    end else begin
                        r_b <= w_bma >> 1;
                    end
                end
                S_VAL: begin
                    if (w_free) begin
                        r_odata <= DATA_W'(r_val);
                        r_ouser <= 1'b0;
                        r_olast <= r_last;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `GCD_ASSERT_IMP(a_gcd_not_last, i_clk, i_rst_n, r_ovalid && r_ouser, !r_olast)
    `GCD_ASSERT_IMP(a_k_bound, i_clk, i_rst_n, r_state == S_GCD, r_k < KW'(IW))
    `GCD_ASSERT_NXT(a_pop_starts, i_clk, i_rst_n, o_pop, r_state != S_IDLE)

endmodule

// File: src/gcd_insert_between_adjacent.sv
// Inserts the greatest common divisor between adjacent values of a stream.
// Slave side (i_s_*): one unsigned value per transfer in tdata, tlast on the
// final value of a sequence. Master side (o_m_*): results in tdata; tuser is 1
// on an inserted gcd and 0 on a passed value; tlast marks the value that ends
// the sequence. The first value of a sequence yields one result, every later
// value yields its gcd with the previous value and then the value itself.
// A front stage tags each value and pushes it into a four-entry queue; the
// back stage pops one entry at a time and runs a binary gcd, one step a cycle.
// With an empty queue and an idle back stage, a value with no gcd passes the
// queue, the S_IDLE and S_VAL states and the output register; with a gcd, the
// gcd leaves the output register after the shift and subtract loop, and the
// value follows it. Sustained rate is that of the gcd loop.
// Bits of a value above VALUE_WIDTH (capped at 32) are dropped.
// Reset clears the queue, the output valid flag and the previous-value state.
// A stall on o_m_tready holds the output register, and the back stage with a
// result; the front fills the queue, then drops i_s ready once it is full.
module gcd_insert_between_adjacent #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] in_value
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] out_value
    output logic        o_m_tuser,   // [0] out_is_gcd
    output logic        o_m_tlast
);
    import gcd_pkg::*;

    localparam int IW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
    localparam int EW = 2 * IW + 2;

    t_q_stat         w_q_stat;
    logic            w_push;
    logic            w_pop;
    logic [EW-1:0]   w_in_entry;
    logic [EW-1:0]   w_out_entry;

    gcd_front #(.IW(IW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_entry    (w_in_entry)
    );

    gcd_queue #(.WIDTH(EW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_in_entry),
        .i_pop   (w_pop),
        .o_data  (w_out_entry),
        .o_stat  (w_q_stat)
    );

    gcd_back #(.IW(IW)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (w_q_stat),
        .i_entry    (w_out_entry),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
